// ===== hdl/qmn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_pkg
// Transaction types and fixed constants shared by the quaternion product
// and normalize pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

	localparam int CompW    = 16;
	localparam int NumLanes = 4;
	localparam int ProdW    = 2 * CompW;
	localparam int SumW     = ProdW + 2;
	localparam int DivW     = 36;
	localparam int CompMax  = 32767;
	localparam int CompMin  = -32768;

	typedef struct packed {
		logic signed [CompW-1:0] a_x;
		logic signed [CompW-1:0] a_y;
		logic signed [CompW-1:0] a_z;
		logic signed [CompW-1:0] a_w;
		logic signed [CompW-1:0] b_x;
		logic signed [CompW-1:0] b_y;
		logic signed [CompW-1:0] b_z;
		logic signed [CompW-1:0] b_w;
		logic                    normalize;
	} item_t;

	typedef struct packed {
		logic signed [CompW-1:0] r_x;
		logic signed [CompW-1:0] r_y;
		logic signed [CompW-1:0] r_z;
		logic signed [CompW-1:0] r_w;
		logic                    saturated;
		logic                    zero_magnitude;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/qmn_product.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_product
// Five-stage front end: partial products, four-term sums, rounding to
// FRAC_BITS, squares of the rounded magnitudes and their sum.
// ----------------------------------------------------------------------------
module qmn_product import qmn_pkg::*; #(
	parameter int FRAC_BITS = 14,
	parameter int PMW       = 19
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire item_t             in_item,
	output logic                   out_valid,
	output logic                   out_norm,
	output logic [NumLanes-1:0]    out_neg,
	output logic [PMW-1:0]         out_mag [NumLanes],
	output logic [2*PMW:0]         out_sq_sum
);

	localparam int QW = 2 * PMW + 1;
	localparam logic [SumW:0] HalfLsb = (SumW + 1)'(1) << (FRAC_BITS - 1);

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                    norm_s1, norm_s2, norm_s3, norm_s4, norm_s5;
	logic signed [ProdW-1:0] prod_s1 [16];
	logic signed [SumW-1:0]  sum_s2 [NumLanes];
	logic [NumLanes-1:0]     neg_s3, neg_s4, neg_s5;
	logic [PMW-1:0]          mag_s3 [NumLanes];
	logic [PMW-1:0]          mag_s4 [NumLanes];
	logic [PMW-1:0]          mag_s5 [NumLanes];
	logic [2*PMW-1:0]        sq_s4 [NumLanes];
	logic [QW-1:0]           sum_sq_s5;

	logic [NumLanes-1:0]     neg_c;
	logic [SumW-1:0]         abs_c [NumLanes];
	logic [SumW:0]           rnd_c [NumLanes];
	logic [PMW-1:0]          mag_c [NumLanes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Round half away from zero on the magnitude
	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			neg_c[i] = sum_s2[i][SumW-1];
			abs_c[i] = neg_c[i] ? SumW'(-sum_s2[i]) : SumW'(sum_s2[i]);
			rnd_c[i] = {1'b0, abs_c[i]} + HalfLsb;
			mag_c[i] = PMW'(rnd_c[i] >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s1     <= in_item.normalize;
			prod_s1[0]  <= $signed(in_item.a_w) * $signed(in_item.b_x);
			prod_s1[1]  <= $signed(in_item.a_x) * $signed(in_item.b_w);
			prod_s1[2]  <= $signed(in_item.a_y) * $signed(in_item.b_z);
			prod_s1[3]  <= $signed(in_item.a_z) * $signed(in_item.b_y);
			prod_s1[4]  <= $signed(in_item.a_w) * $signed(in_item.b_y);
			prod_s1[5]  <= $signed(in_item.a_y) * $signed(in_item.b_w);
			prod_s1[6]  <= $signed(in_item.a_z) * $signed(in_item.b_x);
			prod_s1[7]  <= $signed(in_item.a_x) * $signed(in_item.b_z);
			prod_s1[8]  <= $signed(in_item.a_w) * $signed(in_item.b_z);
			prod_s1[9]  <= $signed(in_item.a_z) * $signed(in_item.b_w);
			prod_s1[10] <= $signed(in_item.a_x) * $signed(in_item.b_y);
			prod_s1[11] <= $signed(in_item.a_y) * $signed(in_item.b_x);
			prod_s1[12] <= $signed(in_item.a_w) * $signed(in_item.b_w);
			prod_s1[13] <= $signed(in_item.a_x) * $signed(in_item.b_x);
			prod_s1[14] <= $signed(in_item.a_y) * $signed(in_item.b_y);
			prod_s1[15] <= $signed(in_item.a_z) * $signed(in_item.b_z);

			norm_s2   <= norm_s1;
			sum_s2[0] <= SumW'(prod_s1[0]) + SumW'(prod_s1[1]) + SumW'(prod_s1[2])
				- SumW'(prod_s1[3]);
			sum_s2[1] <= SumW'(prod_s1[4]) + SumW'(prod_s1[5]) + SumW'(prod_s1[6])
				- SumW'(prod_s1[7]);
			sum_s2[2] <= SumW'(prod_s1[8]) + SumW'(prod_s1[9]) + SumW'(prod_s1[10])
				- SumW'(prod_s1[11]);
			sum_s2[3] <= SumW'(prod_s1[12]) - SumW'(prod_s1[13]) - SumW'(prod_s1[14])
				- SumW'(prod_s1[15]);

			norm_s3 <= norm_s2;
			neg_s3  <= neg_c;
			norm_s4 <= norm_s3;
			neg_s4  <= neg_s3;
			norm_s5 <= norm_s4;
			neg_s5  <= neg_s4;
			for (int i = 0; i < NumLanes; i++) begin
				mag_s3[i] <= mag_c[i];
				mag_s4[i] <= mag_s3[i];
				sq_s4[i]  <= mag_s3[i] * mag_s3[i];
				mag_s5[i] <= mag_s4[i];
			end
			sum_sq_s5 <= QW'(sq_s4[0]) + QW'(sq_s4[1]) + QW'(sq_s4[2]) + QW'(sq_s4[3]);
		end
	end

	assign out_valid  = v_s5;
	assign out_norm   = norm_s5;
	assign out_neg    = neg_s5;
	assign out_mag    = mag_s5;
	assign out_sq_sum = sum_sq_s5;

endmodule
`default_nettype wire

// ===== hdl/qmn_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_sqrt
// Pipelined integer square root, one result bit per register stage, with a
// side tag that travels alongside.
// ----------------------------------------------------------------------------
module qmn_sqrt #(
	parameter int QW = 39,
	parameter int MW = 20,
	parameter int TW = 81
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire logic [QW-1:0] in_val,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_valid,
	output logic [MW-1:0]      out_root,
	output logic [TW-1:0]      out_tag
);

	logic          v_s   [MW+1];
	logic [QW-1:0] rem_s [MW+1];
	logic [QW-1:0] res_s [MW+1];
	logic [TW-1:0] tag_s [MW+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = in_val;
	assign res_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar g = 0; g < MW; g++) begin : g_stage
		localparam logic [QW:0] Bit = (QW + 1)'(1) << (2 * (MW - 1 - g));
		logic [QW:0]   trial;
		logic [QW-1:0] rem_c, res_c;

		always_comb begin
			trial = {1'b0, res_s[g]} + Bit;
			if ({1'b0, rem_s[g]} >= trial) begin
				rem_c = QW'({1'b0, rem_s[g]} - trial);
				res_c = QW'({1'b0, res_s[g] >> 1} + Bit);
			end else begin
				rem_c = rem_s[g];
				res_c = res_s[g] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= rem_c;
				res_s[g+1] <= res_c;
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_valid = v_s[MW];
	assign out_root  = res_s[MW][MW-1:0];
	assign out_tag   = tag_s[MW];

endmodule
`default_nettype wire

// ===== hdl/qmn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmn_div
// Four-lane pipelined restoring divider: rounded |p| * 2^FRAC_BITS / m,
// one quotient bit per stage after a setup stage.
// ----------------------------------------------------------------------------
module qmn_div import qmn_pkg::*; #(
	parameter int FRAC_BITS = 14,
	parameter int PMW       = 19,
	parameter int MW        = 20,
	parameter int TW        = 81
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [PMW-1:0] in_mag [NumLanes],
	input  wire logic [MW-1:0]  in_root,
	input  wire logic [TW-1:0]  in_tag,
	output logic                out_valid,
	output logic                out_zero,
	output logic [FRAC_BITS:0]  out_quo [NumLanes],
	output logic [TW-1:0]       out_tag
);

	localparam int QTW = FRAC_BITS + 1;

	logic              v_s    [QTW+1];
	logic              zero_s [QTW+1];
	logic [DivW-1:0]   dvs_s  [QTW+1];
	logic [TW-1:0]     tag_s  [QTW+1];
	logic [DivW-1:0]   rem_s  [QTW+1][NumLanes];
	logic [QTW-1:0]    quo_s  [QTW+1][NumLanes];

	// Setup: dividend 2*|p|*2^F + m, divisor 2*m
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= (in_root == '0);
			dvs_s[0]  <= DivW'({in_root, 1'b0});
			tag_s[0]  <= in_tag;
			for (int i = 0; i < NumLanes; i++) begin
				rem_s[0][i] <= (DivW'(in_mag[i]) << (FRAC_BITS + 1)) + DivW'(in_root);
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar g = 0; g < QTW; g++) begin : g_stage
		localparam int Sh = QTW - 1 - g;
		logic [DivW-1:0] sub_c;

		assign sub_c = dvs_s[g] << Sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[g+1] <= zero_s[g];
				dvs_s[g+1]  <= dvs_s[g];
				tag_s[g+1]  <= tag_s[g];
				for (int i = 0; i < NumLanes; i++) begin
					if (rem_s[g][i] >= sub_c) begin
						rem_s[g+1][i] <= rem_s[g][i] - sub_c;
						quo_s[g+1][i] <= quo_s[g][i] | (QTW'(1) << Sh);
					end else begin
						rem_s[g+1][i] <= rem_s[g][i];
						quo_s[g+1][i] <= quo_s[g][i];
					end
				end
			end
		end
	end

	assign out_valid = v_s[QTW];
	assign out_zero  = zero_s[QTW];
	assign out_quo   = quo_s[QTW];
	assign out_tag   = tag_s[QTW];

endmodule
`default_nettype wire

// ===== hdl/quaternion_multiply_normalize.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two fixed-point quaternions, optionally divided by its
// magnitude, with saturation and a zero-magnitude flag.
// ----------------------------------------------------------------------------
// Usage:
//   item_valid/item_stall/item carry one quaternion pair and the normalize
//   flag per transaction; result_valid/result_stall/result return one result
//   transaction per input transaction, in order.
//   The path is five product/round/square stages, 34-FRAC_BITS square root
//   stages, FRAC_BITS+2 divider stages and the output register. Raw products
//   run the same path, so order is kept.
//   Throughput is one transaction per cycle; the whole pipe advances together
//   and the item side is stalled only while a result is held in the output
//   register and the receiver stalls.
//   Reset clears every stage valid bit; payload registers keep garbage that
//   is never shown. On a receiver stall, hold the output register and freeze
//   every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize import qmn_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int PMW = 33 - FRAC_BITS;      // rounded component magnitude
	localparam int QW  = 2 * PMW + 1;         // sum of squares
	localparam int MW  = 34 - FRAC_BITS;      // square root
	localparam int TW  = 1 + NumLanes + NumLanes * PMW;
	localparam logic signed [DivW-1:0] MaxV = DivW'(CompMax);
	localparam logic signed [DivW-1:0] MinV = DivW'(CompMin);

	logic adv;

	logic                pr_valid, pr_norm;
	logic [NumLanes-1:0] pr_neg;
	logic [PMW-1:0]      pr_mag [NumLanes];
	logic [QW-1:0]       pr_sq_sum;
	logic [TW-1:0]       pr_tag;

	logic                sq_valid;
	logic [MW-1:0]       sq_root;
	logic [TW-1:0]       sq_tag;
	logic [PMW-1:0]      sq_mag [NumLanes];

	logic                dv_valid, dv_zero;
	logic [FRAC_BITS:0]  dv_quo [NumLanes];
	logic [TW-1:0]       dv_tag;

	logic                dv_norm;
	logic [NumLanes-1:0] dv_neg;
	logic [PMW-1:0]      dv_mag [NumLanes];

	logic signed [DivW-1:0] val_c [NumLanes];
	logic [CompW-1:0]       comp_c [NumLanes];
	logic                   sat_c;
	result_t                result_c;

	logic    out_valid_q;
	result_t out_q;

	// Advance every stage unless a finished result is waiting on a stall
	assign adv        = !out_valid_q || !result_stall;
	assign item_stall = !adv;

	qmn_product #(
		.FRAC_BITS (FRAC_BITS),
		.PMW       (PMW)
	) u_product (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (item_valid),
		.in_item    (item),
		.out_valid  (pr_valid),
		.out_norm   (pr_norm),
		.out_neg    (pr_neg),
		.out_mag    (pr_mag),
		.out_sq_sum (pr_sq_sum)
	);

	// Pack the normalize flag and the sign and magnitude of each component to ride along the root
	always_comb begin
		pr_tag = '0;
		pr_tag[TW-1] = pr_norm;
		pr_tag[NumLanes*PMW +: NumLanes] = pr_neg;
		for (int i = 0; i < NumLanes; i++) begin
			pr_tag[i*PMW +: PMW] = pr_mag[i];
		end
	end

	qmn_sqrt #(
		.QW (QW),
		.MW (MW),
		.TW (TW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pr_valid),
		.in_val    (pr_sq_sum),
		.in_tag    (pr_tag),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			sq_mag[i] = sq_tag[i*PMW +: PMW];
		end
	end

	qmn_div #(
		.FRAC_BITS (FRAC_BITS),
		.PMW       (PMW),
		.MW        (MW),
		.TW        (TW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sq_valid),
		.in_mag    (sq_mag),
		.in_root   (sq_root),
		.in_tag    (sq_tag),
		.out_valid (dv_valid),
		.out_zero  (dv_zero),
		.out_quo   (dv_quo),
		.out_tag   (dv_tag)
	);

	// Pick raw or normalized value, restore sign, clamp to 16 bits; zero on a zero magnitude
	always_comb begin
		dv_norm = dv_tag[TW-1];
		dv_neg  = dv_tag[NumLanes*PMW +: NumLanes];
		sat_c   = 1'b0;
		for (int i = 0; i < NumLanes; i++) begin
			dv_mag[i] = dv_tag[i*PMW +: PMW];
			if (dv_norm) begin
				val_c[i] = dv_neg[i] ? -$signed(DivW'(dv_quo[i])) : $signed(DivW'(dv_quo[i]));
			end else begin
				val_c[i] = dv_neg[i] ? -$signed(DivW'(dv_mag[i])) : $signed(DivW'(dv_mag[i]));
			end
			if (dv_norm && dv_zero) begin
				comp_c[i] = '0;
			end else if (val_c[i] > MaxV) begin
				comp_c[i] = CompW'(MaxV);
				sat_c     = 1'b1;
			end else if (val_c[i] < MinV) begin
				comp_c[i] = CompW'(MinV);
				sat_c     = 1'b1;
			end else begin
				comp_c[i] = val_c[i][CompW-1:0];
			end
		end
		result_c.r_x            = comp_c[0];
		result_c.r_y            = comp_c[1];
		result_c.r_z            = comp_c[2];
		result_c.r_w            = comp_c[3];
		result_c.saturated      = sat_c;
		result_c.zero_magnitude = dv_norm && dv_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result_c;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion product and normalize pipeline:
// a directed table followed by random quaternion pairs, every result checked
// in order against a typed-in answer or a behavioral model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
	import qmn_pkg::*;

	localparam int FRAC     = 14;
	localparam int LATENCY  = 42;
	localparam int N_RANDOM = 550;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [CompW-1:0] ONE  = 16'sd16384;
	localparam logic [CompW-1:0] MAXV = 16'h7FFF;
	localparam logic [CompW-1:0] MINV = 16'h8000;

	typedef struct {
		item_t   it;
		logic    known;  // expected result typed in the table
		result_t res;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t expected_results[$];
	int      n_errors;
	longint  cycles;
	logic    stim_done;
	logic    hold_off;  // long receiver stall for back-pressure
	row_t    table_rows[$];

	quaternion_multiply_normalize #(.FRAC_BITS(FRAC)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round a product sum half away from zero to FRAC fraction bits.
	function automatic longint round_sum(longint s);
		longint m;
		m = ((s < 0 ? -s : s) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
		return s < 0 ? -m : m;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r, bt;
		r  = 0;
		bt = 64'sd1 <<< 62;
		while (bt > n) bt = bt >>> 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n = n - (r + bt);
				r = (r >>> 1) + bt;
			end else begin
				r = r >>> 1;
			end
			bt = bt >>> 2;
		end
		return r;
	endfunction

	// Compute the Hamilton product, optionally normalized, saturated to 16 bits.
	function automatic result_t hamilton_product(item_t t);
		longint ax, ay, az, aw, bx, by, bz, bw, q, m, mag, a;
		longint p[4];
		result_t r;
		logic [CompW-1:0] c[4];
		ax = t.a_x; ay = t.a_y; az = t.a_z; aw = t.a_w;
		bx = t.b_x; by = t.b_y; bz = t.b_z; bw = t.b_w;
		p[0] = round_sum(aw*bx + ax*bw + ay*bz - az*by);
		p[1] = round_sum(aw*by + ay*bw + az*bx - ax*bz);
		p[2] = round_sum(aw*bz + az*bw + ax*by - ay*bx);
		p[3] = round_sum(aw*bw - ax*bx - ay*by - az*bz);
		r = '0;
		if (t.normalize) begin
			q = 0;
			for (int i = 0; i < 4; i++) q += p[i] * p[i];
			m = int_sqrt(q);
			if (m == 0) begin
				r.zero_magnitude = 1'b1;
				for (int i = 0; i < 4; i++) p[i] = 0;
			end else begin
				for (int i = 0; i < 4; i++) begin
					a    = p[i] < 0 ? -p[i] : p[i];
					mag  = (2 * (a <<< FRAC) + m) / (2 * m);
					p[i] = p[i] < 0 ? -mag : mag;
				end
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (p[i] > CompMax) begin
				p[i] = CompMax;
				r.saturated = 1'b1;
			end
			if (p[i] < CompMin) begin
				p[i] = CompMin;
				r.saturated = 1'b1;
			end
			c[i] = p[i][CompW-1:0];
		end
		r.r_x = c[0]; r.r_y = c[1]; r.r_z = c[2]; r.r_w = c[3];
		return r;
	endfunction

	function automatic item_t pair(logic [15:0] ax, ay, az, aw, bx, by, bz, bw, logic nz);
		item_t t;
		t = '{ax, ay, az, aw, bx, by, bz, bw, nz};
		return t;
	endfunction

	function automatic result_t res_of(logic [15:0] x, y, z, w, logic s, logic zm);
		result_t r;
		r = '{x, y, z, w, s, zm};
		return r;
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 9))
			0:       return MAXV;
			1:       return MINV;
			2:       return $urandom_range(0, 1) ? ONE : -ONE;
			3:       return 16'($urandom_range(0, 63) - 32);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t t;
		t = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(),
			rand_comp(), rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 3) != 0};
		return t;
	endfunction

	// Random gap: mostly none or short, now and then long.
	function automatic int gap_len();
		int g;
		g = $urandom_range(0, 99);
		if (g < 50) return 0;
		if (g < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one transaction and hold it until accepted.
	task automatic send_item(item_t t);
		item_valid <= 1'b1;
		item       <= t;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic offer(item_t t);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_item(t);
		expected_results.push_back(hamilton_product(t));
	endtask

	// Directed rows: extremes, identities, zero magnitude, saturation.
	task automatic build_table();
		row_t r;
		r.known = 1'b1;
		r.it = pair(0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0);
		r.res = res_of(0, 0, 0, ONE, 1'b0, 1'b0); table_rows.push_back(r);
		r.it = pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
		r.res = res_of(0, 0, 0, 0, 1'b0, 1'b1); table_rows.push_back(r);
		r.it = pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		r.res = res_of(0, 0, 0, 0, 1'b0, 1'b0); table_rows.push_back(r);
		// tiny product rounds to zero: zero magnitude
		r.it = pair(0, 0, 0, 1, 0, 0, 0, 1, 1'b1);
		r.res = res_of(0, 0, 0, 0, 1'b0, 1'b1); table_rows.push_back(r);
		// i*i = -1
		r.it = pair(ONE, 0, 0, 0, ONE, 0, 0, 0, 1'b0);
		r.res = res_of(0, 0, 0, -ONE, 1'b0, 1'b0); table_rows.push_back(r);
		// min*min = 4.0 saturates
		r.it = pair(0, 0, 0, MINV, 0, 0, 0, MINV, 1'b0);
		r.res = res_of(0, 0, 0, MAXV, 1'b1, 1'b0); table_rows.push_back(r);
		// normalized unit w comes out at 1.0 = 16384, fits
		r.it = pair(0, 0, 0, MINV, 0, 0, 0, MINV, 1'b1);
		r.res = res_of(0, 0, 0, ONE, 1'b0, 1'b0); table_rows.push_back(r);
		r.known = 1'b0;
		r.it = pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b0); table_rows.push_back(r);
		r.it = pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1); table_rows.push_back(r);
		r.it = pair(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b0); table_rows.push_back(r);
		r.it = pair(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1); table_rows.push_back(r);
		r.it = pair(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, 1'b0); table_rows.push_back(r);
		r.it = pair(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, 1'b1); table_rows.push_back(r);
		r.it = pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1, 1'b1); table_rows.push_back(r);
		r.it = pair(ONE, ONE, ONE, ONE, ONE, -ONE, ONE, -ONE, 1'b1); table_rows.push_back(r);
		r.it = pair(1234, -567, 8901, -2345, 6789, -123, 4567, -8901, 1'b0); table_rows.push_back(r);
		r.it = pair(1234, -567, 8901, -2345, 6789, -123, 4567, -8901, 1'b1); table_rows.push_back(r);
		r.it = pair(8192, 0, 0, 0, 0, 2, 0, 0, 1'b1); table_rows.push_back(r);
		r.it = pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 1'b1); table_rows.push_back(r);
	endtask

	// Reset and stimulus.
	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		stim_done  = 1'b0;
		build_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) begin
			send_item(table_rows[i].it);
			// Table rows with a typed-in answer skip the model.
			expected_results.push_back(table_rows[i].known ? table_rows[i].res
				: hamilton_product(table_rows[i].it));
		end
		for (int i = 0; i < N_RANDOM; i++) offer(rand_item());
		item_valid <= 1'b0;
		stim_done  <= 1'b1;
	end

	// Back-pressure: one long hold-off early in the random part.
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (150) @(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Receiver stall: random gaps, with calm stretches in between.
	initial begin
		int g;
		result_stall = 1'b1;
		wait (arst_n);
		forever begin
			result_stall <= hold_off;
			repeat ($urandom_range(5, 40)) @(posedge clk);
			g = gap_len();
			if (g > 0) begin
				result_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Check each accepted result transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction %p", result);
				n_errors++;
			end else begin
				e = expected_results.pop_front();
				if (result.r_x !== e.r_x) begin
					$error("r_x expected %0d actual %0d", e.r_x, result.r_x); n_errors++;
				end
				if (result.r_y !== e.r_y) begin
					$error("r_y expected %0d actual %0d", e.r_y, result.r_y); n_errors++;
				end
				if (result.r_z !== e.r_z) begin
					$error("r_z expected %0d actual %0d", e.r_z, result.r_z); n_errors++;
				end
				if (result.r_w !== e.r_w) begin
					$error("r_w expected %0d actual %0d", e.r_w, result.r_w); n_errors++;
				end
				if (result.saturated !== e.saturated) begin
					$error("saturated expected %0b actual %0b", e.saturated, result.saturated);
					n_errors++;
				end
				if (result.zero_magnitude !== e.zero_magnitude) begin
					$error("zero_magnitude expected %0b actual %0b", e.zero_magnitude,
						result.zero_magnitude);
					n_errors++;
				end
			end
		end
	end

	// Drain, then report; a cycle counter guards against a hang.
	initial begin
		n_errors = 0;
		cycles   = 0;
		fork
			begin
				wait (stim_done);
				while (expected_results.size() != 0) @(posedge clk);
				repeat (2 * LATENCY) @(posedge clk);
				if (n_errors == 0)
					$display("** quaternion_multiply_normalize: PASSED **");
				else
					$display("** quaternion_multiply_normalize: FAILED **");
				$finish;
			end
			begin
				while (cycles < CYCLE_LIMIT) begin
					@(posedge clk);
					cycles++;
				end
				$error("timeout after %0d cycles", cycles);
				$display("** quaternion_multiply_normalize: FAILED **");
				$finish;
			end
		join
	end

endmodule

// ===== sim.f =====
hdl/qmn_pkg.sv
hdl/qmn_product.sv
hdl/qmn_sqrt.sv
hdl/qmn_div.sv
hdl/quaternion_multiply_normalize.sv
tb/tb_top.sv
